>>> hdl/mip_box_downsample_2x2_defines.svh
// ----------------------------------------------------------------------------
// mip_box_downsample_2x2 assertion macros
// Shared property macros for the mip downsampler; they assume clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef MIP_BOX_DOWNSAMPLE_2X2_DEFINES_SVH
`define MIP_BOX_DOWNSAMPLE_2X2_DEFINES_SVH

// same-cycle implication
`define MBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg
// Constants, types and sRGB conversion tables for the 2x2 mip downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CFG_W         = 13;
  localparam int ROW_W         = 12;
  localparam int PIX_W         = 8;
  localparam int NUM_CH        = 4;
  localparam int NUM_COLOR     = 3;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;
  localparam int REG_IDX_W     = 2;

  localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHAN_COUNT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SRGB_MODE  = 2'd3;

  localparam logic [2:0] CH_MIN = 3'd1;
  localparam logic [2:0] CH_MAX = 3'd4;

  typedef logic [255:0][PIX_W-1:0] tab_t;
  typedef logic [255:0]            big_t;

  // effective configuration seen by the lanes
  typedef struct packed {
    logic [2:0] nc;
    logic       srgb;
  } cfg_t;

  // per-cycle lane control
  typedef struct packed {
    logic hold_we;   // latch left pixel of a pair
    logic s1_load;   // pair sum enters stage 1
    logic w1;        // single column: pixel pairs with itself
    logic s1_go;     // stage 1 moves on
    logic mem_we;    // line store write (even row)
    logic mem_re;    // line store read (odd row)
    logic s2_h1;     // single row: pair sum doubles
  } lane_ctl_t;

  function automatic int idx_bits(input int max_width);
    int depth;
    depth = (max_width + 1) / 2;
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic big_t big_pow(input big_t base, input int e);
    big_t acc;
    acc = big_t'(1);
    for (int i = 0; i < 12; i++) begin
      if (i < e) acc = acc * base;
    end
    return acc;
  endfunction

  // a^ae * b^be <= c^ce * d^de, exact
  function automatic logic pow_le(input int a, input int ae, input int b, input int be,
                                  input int c, input int ce, input int d, input int de);
    big_t l;
    big_t r;
    l = big_pow(big_t'(a), ae) * big_pow(big_t'(b), be);
    r = big_pow(big_t'(c), ce) * big_pow(big_t'(d), de);
    return l <= r;
  endfunction

  function automatic tab_t build_lin();
    tab_t t;
    int   k;
    logic done;
    k = 0;
    for (int v = 0; v < 256; v++) begin
      if (v <= 10) begin
        k = (v * 100) / 1292;
      end else begin
        done = 1'b0;
        for (int s = 0; s < 256; s++) begin
          if (!done) begin
            if (k < 255 && pow_le(k + 1, 5, 10761, 12, 255, 5, 40 * v + 561, 12)) k++;
            else done = 1'b1;
          end
        end
      end
      t[v] = PIX_W'(k);
    end
    return t;
  endfunction

  function automatic tab_t build_srgb();
    tab_t t;
    int   k;
    logic done;
    k = 0;
    t[0] = '0;
    for (int v = 1; v < 256; v++) begin
      done = 1'b0;
      for (int s = 0; s < 256; s++) begin
        if (!done) begin
          if (k < 255 && pow_le(40 * (k + 1) + 561, 12, 255, 5, v, 5, 10761, 12)) k++;
          else done = 1'b1;
        end
      end
      t[v] = PIX_W'(k);
    end
    return t;
  endfunction

  localparam tab_t LIN_TAB  = build_lin();
  localparam tab_t SRGB_TAB = build_srgb();

endpackage

`default_nettype wire

>>> hdl/mbd_ctrl.sv
// ----------------------------------------------------------------------------
// mbd_ctrl
// Register port, raster counters and stage sequencing for the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_ctrl #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mbd_pkg::ADDR_W-1:0]             paddr,
  input  logic [mbd_pkg::DATA_W-1:0]             pwdata,
  output logic [mbd_pkg::DATA_W-1:0]             prdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   out_free,
  output mbd_pkg::lane_ctl_t                     lane_ctl,
  output mbd_pkg::cfg_t                          lane_cfg,
  output logic [mbd_pkg::idx_bits(MAX_WIDTH)-1:0] s1_idx,
  output logic                                   s2_go,
  output logic                                   s2_last
);
  import mbd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WEF_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WEF_W > CFG_W) ? WEF_W : CFG_W;
  localparam int IDX_W = idx_bits(MAX_WIDTH);

  logic [CFG_W-1:0]     src_width_r, src_height_r;
  logic [2:0]           chan_cnt_r;
  logic                 srgb_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  logic [WEF_W-1:0] w_eff, col_lim, nw_m1, col_inc;
  logic [CFG_W-1:0] h_eff, row_lim, nh_m1, row_inc;
  logic             w1, h1, col_act, row_act, blk_act, pair_rdy, even_row, last;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             s1_vld_r, s1_wr_r, s1_rd_r, s1_h1_r, s1_last_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_vld_r, s2_h1_r, s2_last_r;
  logic             s1_go, s1_free, s2_free, acc, s1_load;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= CFG_W'(4096);
      src_height_r <= CFG_W'(4096);
      chan_cnt_r   <= CH_MAX;
      srgb_r       <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  src_width_r  <= pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT: src_height_r <= pwdata[CFG_W-1:0];
        REG_CHAN_COUNT: chan_cnt_r   <= pwdata[2:0];
        REG_SRGB_MODE:  srgb_r       <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  prdata = DATA_W'(src_width_r);
      REG_SRC_HEIGHT: prdata = DATA_W'(src_height_r);
      REG_CHAN_COUNT: prdata = DATA_W'(chan_cnt_r);
      REG_SRGB_MODE:  prdata = DATA_W'(srgb_r);
    endcase
  end

  // clamp the geometry and channel count
  always_comb begin
    if (src_width_r == '0) w_eff = WEF_W'(1);
    else if (CMP_W'(src_width_r) > CMP_W'(MAX_WIDTH)) w_eff = WEF_W'(MAX_WIDTH);
    else w_eff = WEF_W'(src_width_r);

    if (src_height_r == '0) h_eff = CFG_W'(1);
    else if (src_height_r > CFG_W'(MAX_HEIGHT)) h_eff = CFG_W'(MAX_HEIGHT);
    else h_eff = src_height_r;

    if (chan_cnt_r == '0) lane_cfg.nc = CH_MIN;
    else if (chan_cnt_r > CH_MAX) lane_cfg.nc = CH_MAX;
    else lane_cfg.nc = chan_cnt_r;
    lane_cfg.srgb = srgb_r;
  end

  always_comb begin
    w1       = (w_eff == WEF_W'(1));
    h1       = (h_eff == CFG_W'(1));
    col_lim  = w1 ? WEF_W'(2) : (w_eff & ~WEF_W'(1));
    row_lim  = h1 ? CFG_W'(2) : (h_eff & ~CFG_W'(1));
    nw_m1    = w1 ? '0 : (w_eff >> 1) - WEF_W'(1);
    nh_m1    = h1 ? '0 : (h_eff >> 1) - CFG_W'(1);
    col_act  = WEF_W'(col_r) < col_lim;
    row_act  = CFG_W'(row_r) < row_lim;
    blk_act  = col_act && row_act;
    pair_rdy = w1 || col_r[0];
    even_row = !row_r[0];
    last     = (WEF_W'(col_r >> 1) == nw_m1) && (CFG_W'(row_r >> 1) == nh_m1);
  end

  // stage handshakes; a stage frees when the one after it frees
  always_comb begin
    s2_free  = !s2_vld_r || out_free;
    s2_go    = s2_vld_r && out_free;
    s1_go    = s1_vld_r && s2_free;
    s1_free  = !s1_vld_r || s2_free;
    in_stall = !s1_free;
    acc      = in_valid && s1_free;
    s1_load  = acc && blk_act && pair_rdy;
  end

  always_comb begin
    col_inc = WEF_W'(col_r) + WEF_W'(1);
    row_inc = CFG_W'(row_r) + CFG_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (s1_load) s1_vld_r <= 1'b1;
      else if (s1_go) s1_vld_r <= 1'b0;
      if (s1_go) s2_vld_r <= s1_h1_r || s1_rd_r;
      else if (s2_go) s2_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_wr_r   <= !h1 && even_row;
      s1_rd_r   <= !h1 && !even_row;
      s1_h1_r   <= h1;
      s1_last_r <= last;
      s1_idx_r  <= IDX_W'(col_r >> 1);
    end
    if (s1_go) begin
      s2_h1_r   <= s1_h1_r;
      s2_last_r <= s1_last_r;
    end
  end

  always_comb begin
    lane_ctl.hold_we = acc && blk_act && !w1 && !col_r[0];
    lane_ctl.s1_load = s1_load;
    lane_ctl.w1      = w1;
    lane_ctl.s1_go   = s1_go;
    lane_ctl.mem_we  = s1_go && s1_wr_r;
    lane_ctl.mem_re  = s1_go && s1_rd_r;
    lane_ctl.s2_h1   = s2_h1_r;
  end

  assign s1_idx  = s1_idx_r;
  assign s2_last = s2_last_r;

endmodule

`default_nettype wire

>>> hdl/mbd_lane.sv
// ----------------------------------------------------------------------------
// mbd_lane
// One channel: linearize, pair sum, line store, block mean, back to sRGB.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_lane #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF,
  parameter int LANE      = 0
) (
  input  logic                                   clk,
  input  mbd_pkg::lane_ctl_t                     ctl,
  input  mbd_pkg::cfg_t                          cfg,
  input  logic [mbd_pkg::idx_bits(MAX_WIDTH)-1:0] idx,
  input  logic [mbd_pkg::PIX_W-1:0]              pix_in,
  output logic [mbd_pkg::PIX_W-1:0]              res
);
  import mbd_pkg::*;

  localparam int   LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam logic IS_COLOR   = (LANE < NUM_COLOR);

  logic             lane_on, conv;
  logic [PIX_W-1:0] v, hold_r, mean;
  logic [PIX_W:0]   pair, s1_pair_r, s2_pair_r, rd_r;
  logic [PIX_W+1:0] total;

  // pair sums of even rows, one entry per column pair
  logic [PIX_W:0]   line_mem [LINE_DEPTH];

  assign lane_on = cfg.nc > 3'(LANE);
  assign conv    = cfg.srgb && IS_COLOR;

  always_comb begin
    if (!lane_on) v = '0;
    else if (conv) v = LIN_TAB[pix_in];
    else v = pix_in;
    pair = ctl.w1 ? {v, 1'b0} : (PIX_W+1)'(hold_r) + (PIX_W+1)'(v);
  end

  always_ff @(posedge clk) begin
    if (ctl.hold_we) hold_r <= v;
    if (ctl.s1_load) s1_pair_r <= pair;
    if (ctl.s1_go) s2_pair_r <= s1_pair_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_we) line_mem[idx] <= s1_pair_r;
    if (ctl.mem_re) rd_r <= line_mem[idx];
  end

  always_comb begin
    total = ctl.s2_h1 ? {s2_pair_r, 1'b0} : (PIX_W+2)'(rd_r) + (PIX_W+2)'(s2_pair_r);
    mean  = total[PIX_W+1:2];
    if (!lane_on) res = '0;
    else if (conv) res = SRGB_TAB[mean];
    else res = mean;
  end

endmodule

`default_nettype wire

>>> hdl/mbd_merge.sv
// ----------------------------------------------------------------------------
// mbd_merge
// Gathers the lane results and the end-of-level flag into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_merge (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     load,
  input  logic                                     last_in,
  input  logic [mbd_pkg::NUM_CH-1:0][mbd_pkg::PIX_W-1:0] lane_res,
  input  logic                                     out_stall,
  output logic                                     out_free,
  output logic                                     out_valid,
  output logic [mbd_pkg::PIX_W-1:0]                out_chan0,
  output logic [mbd_pkg::PIX_W-1:0]                out_chan1,
  output logic [mbd_pkg::PIX_W-1:0]                out_chan2,
  output logic [mbd_pkg::PIX_W-1:0]                out_chan3,
  output logic                                     out_last_pixel
);
  import mbd_pkg::*;

  logic                             out_vld_r, last_r;
  logic [NUM_CH-1:0][PIX_W-1:0]     pix_r;

  assign out_free = !out_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_free) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r  <= lane_res;
      last_r <= last_in;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_chan0      = pix_r[0];
  assign out_chan1      = pix_r[1];
  assign out_chan2      = pix_r[2];
  assign out_chan3      = pix_r[3];
  assign out_last_pixel = last_r;

endmodule

`default_nettype wire

>>> hdl/mip_box_downsample_2x2.sv
// ----------------------------------------------------------------------------
// mip_box_downsample_2x2
// Streaming 2x2 box-filter mip level generator with optional sRGB averaging.
// ----------------------------------------------------------------------------
// Source pixels come in raster order, one transfer per pixel, and one result
// transfer leaves for every 2x2 block: the truncated per-channel mean. The
// block takes one pixel per clock while the output side keeps up; a result
// shows on out_valid once the pixel that completes its block has passed
// stage 1, stage 2 (which the line store read also feeds) and the output
// register. Four channel lanes run side by side, each with its own
// sRGB-to-linear and linear-to-sRGB tables (built at elaboration) and its own
// slice of the line store: (MAX_WIDTH+1)/2 entries of 9-bit pair sums, written
// on even rows and read back on odd rows. The store needs no clearing pass,
// since every entry is written before it is read. Odd trailing rows/columns
// are dropped; a width or height of one pairs the single column/row with
// itself. Any register write restarts the image at its top-left pixel;
// registers must only be written while no transfer is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mip_box_downsample_2x2_defines.svh"

module mip_box_downsample_2x2 #(
  parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbd_pkg::ADDR_W-1:0]    paddr,
  input  logic [mbd_pkg::DATA_W-1:0]    pwdata,
  output logic [mbd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // source pixels
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mbd_pkg::PIX_W-1:0]     in_chan0,
  input  logic [mbd_pkg::PIX_W-1:0]     in_chan1,
  input  logic [mbd_pkg::PIX_W-1:0]     in_chan2,
  input  logic [mbd_pkg::PIX_W-1:0]     in_chan3,
  // downsampled pixels
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mbd_pkg::PIX_W-1:0]     out_chan0,
  output logic [mbd_pkg::PIX_W-1:0]     out_chan1,
  output logic [mbd_pkg::PIX_W-1:0]     out_chan2,
  output logic [mbd_pkg::PIX_W-1:0]     out_chan3,
  output logic                          out_last_pixel
);
  import mbd_pkg::*;

  localparam int IDX_W = idx_bits(MAX_WIDTH);

  lane_ctl_t                    lane_ctl;
  cfg_t                         lane_cfg;
  logic [IDX_W-1:0]             s1_idx;
  logic                         s2_go, s2_last, out_free;
  logic [NUM_CH-1:0][PIX_W-1:0] in_pix, lane_res;

  // register port never waits
  assign pready = 1'b1;

  assign in_pix = {in_chan3, in_chan2, in_chan1, in_chan0};

  // counters, register file and the stage valids
  mbd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .lane_ctl (lane_ctl),
    .lane_cfg (lane_cfg),
    .s1_idx   (s1_idx),
    .s2_go    (s2_go),
    .s2_last  (s2_last)
  );

  // one lane per channel; alpha lane never converts
  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    mbd_lane #(
      .MAX_WIDTH (MAX_WIDTH),
      .LANE      (g)
    ) u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .cfg    (lane_cfg),
      .idx    (s1_idx),
      .pix_in (in_pix[g]),
      .res    (lane_res[g])
    );
  end

  // output register: the result waits here while stages upstream keep filling
  mbd_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (s2_go),
    .last_in        (s2_last),
    .lane_res       (lane_res),
    .out_stall      (out_stall),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_chan0      (out_chan0),
    .out_chan1      (out_chan1),
    .out_chan2      (out_chan2),
    .out_chan3      (out_chan3),
    .out_last_pixel (out_last_pixel)
  );

  // a held result is never overwritten by the stage behind it
  `MBD_ASSERT_SAME(a_hold_result, out_valid && out_stall, !s2_go, "held result overwritten")
  // a result moved into the output register is presented next cycle
  `MBD_ASSERT_NEXT(a_load_shows, s2_go, out_valid, "loaded result not presented")
  // the line store port serves either a write or a read in one cycle
  `MBD_ASSERT_SAME(a_line_port, lane_ctl.mem_we, !lane_ctl.mem_re, "line store port collision")

endmodule

`default_nettype wire
